// File: rtl/core/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared types, operation codes and datapath command codes for the gravity
// body integrator.
// ----------------------------------------------------------------------------
package gbi_pkg;

    // Operation codes carried in the input item.
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_ATTRACT = 3'd1;
    localparam logic [2:0] OP_VEL    = 3'd2;
    localparam logic [2:0] OP_POS    = 3'd3;
    localparam logic [2:0] OP_CLRACC = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_STEP = 1'b1;

    // Datapath command codes.
    typedef logic [4:0] t_cmd_code;
    localparam t_cmd_code C_IDLE      = 5'd0;
    localparam t_cmd_code C_LATCH     = 5'd1;
    localparam t_cmd_code C_LOAD      = 5'd2;
    localparam t_cmd_code C_CLRACC    = 5'd3;
    localparam t_cmd_code C_DIFF      = 5'd4;
    localparam t_cmd_code C_MUL_DX    = 5'd5;
    localparam t_cmd_code C_MUL_DY    = 5'd6;
    localparam t_cmd_code C_SUM       = 5'd7;
    localparam t_cmd_code C_SQ_INIT   = 5'd8;
    localparam t_cmd_code C_SQ_STEP   = 5'd9;
    localparam t_cmd_code C_CDIV_INIT = 5'd10;
    localparam t_cmd_code C_DIV_STEP  = 5'd11;
    localparam t_cmd_code C_P_LO      = 5'd12;
    localparam t_cmd_code C_P_HI      = 5'd13;
    localparam t_cmd_code C_MDIV_INIT = 5'd14;
    localparam t_cmd_code C_ACC       = 5'd15;
    localparam t_cmd_code C_VMUL      = 5'd16;
    localparam t_cmd_code C_VADD      = 5'd17;
    localparam t_cmd_code C_PM1       = 5'd18;
    localparam t_cmd_code C_PM2       = 5'd19;
    localparam t_cmd_code C_PM3       = 5'd20;
    localparam t_cmd_code C_PM4       = 5'd21;
    localparam t_cmd_code C_PM5       = 5'd22;
    localparam t_cmd_code C_PUBLISH   = 5'd23;

    // Iteration counts of the shared square root and divider steps.
    localparam logic [5:0] SQ_STEPS   = 6'd32;
    localparam logic [5:0] CDIV_STEPS = 6'd32;
    localparam logic [5:0] MDIV_STEPS = 6'd33;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_cmd_code code;
        logic      axis;   // 0 selects x, 1 selects y
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_dist;
    } t_dp_status;

    // Saturate a signed 64-bit value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Magnitude of a signed 32-bit value as unsigned 32 bits.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? 32'(-v) : 32'(v);
        return res;
    endfunction

endpackage

// File: rtl/core/gbi_ctrl.sv
// ----------------------------------------------------------------------------
// gbi_ctrl
// Sequencer for the gravity body integrator: accepts an item, steps the
// datapath through the operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module gbi_ctrl
    import gbi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_op,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_ZCHK = 5'd2;
    localparam logic [4:0] S_MDY  = 5'd3;
    localparam logic [4:0] S_SUM  = 5'd4;
    localparam logic [4:0] S_SQI  = 5'd5;
    localparam logic [4:0] S_SQ   = 5'd6;
    localparam logic [4:0] S_CDI  = 5'd7;
    localparam logic [4:0] S_CDIV = 5'd8;
    localparam logic [4:0] S_PLO  = 5'd9;
    localparam logic [4:0] S_PHI  = 5'd10;
    localparam logic [4:0] S_MDI  = 5'd11;
    localparam logic [4:0] S_MDIV = 5'd12;
    localparam logic [4:0] S_ACC  = 5'd13;
    localparam logic [4:0] S_VMUL = 5'd14;
    localparam logic [4:0] S_VADD = 5'd15;
    localparam logic [4:0] S_PM1  = 5'd16;
    localparam logic [4:0] S_PM2  = 5'd17;
    localparam logic [4:0] S_PM3  = 5'd18;
    localparam logic [4:0] S_PM4  = 5'd19;
    localparam logic [4:0] S_PM5  = 5'd20;
    localparam logic [4:0] S_FIN  = 5'd21;

    logic [4:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_axis, n_axis;
    logic [2:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       in_fire;
    logic       out_free;

    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.code  = C_IDLE;
        o_cmd.axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.code = C_LATCH;
                    n_op       = i_in_op;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_axis = 1'b0;
                priority if (r_op == OP_LOAD) begin
                    o_cmd.code = C_LOAD;
                    n_state    = S_FIN;
                end else if (r_op == OP_CLRACC) begin
                    o_cmd.code = C_CLRACC;
                    n_state    = S_FIN;
                end else if (r_op == OP_ATTRACT) begin
                    o_cmd.code = C_DIFF;
                    n_state    = S_ZCHK;
                end else if (r_op == OP_VEL) begin
                    n_state = S_VMUL;
                end else if (r_op == OP_POS) begin
                    n_state = S_PM1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ZCHK: begin
                if (i_status.zero_dist) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.code = C_MUL_DX;
                    n_state    = S_MDY;
                end
            end
            S_MDY: begin
                o_cmd.code = C_MUL_DY;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.code = C_SUM;
                n_state    = S_SQI;
            end
            S_SQI: begin
                o_cmd.code = C_SQ_INIT;
                n_cnt      = '0;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.code = C_SQ_STEP;
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == SQ_STEPS - 6'd1) begin
                    n_state = S_CDI;
                end
            end
            S_CDI: begin
                o_cmd.code = C_CDIV_INIT;
                n_cnt      = '0;
                n_state    = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.code = C_DIV_STEP;
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == CDIV_STEPS - 6'd1) begin
                    n_state = S_PLO;
                end
            end
            S_PLO: begin
                o_cmd.code = C_P_LO;
                n_state    = S_PHI;
            end
            S_PHI: begin
                o_cmd.code = C_P_HI;
                n_state    = S_MDI;
            end
            S_MDI: begin
                o_cmd.code = C_MDIV_INIT;
                n_cnt      = '0;
                n_state    = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.code = C_DIV_STEP;
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == MDIV_STEPS - 6'd1) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.code = C_ACC;
                n_axis     = 1'b1;
                n_state    = r_axis ? S_FIN : S_CDI;
            end
            S_VMUL: begin
                o_cmd.code = C_VMUL;
                n_state    = S_VADD;
            end
            S_VADD: begin
                o_cmd.code = C_VADD;
                n_axis     = 1'b1;
                n_state    = r_axis ? S_FIN : S_VMUL;
            end
            S_PM1: begin
                o_cmd.code = C_PM1;
                n_state    = S_PM2;
            end
            S_PM2: begin
                o_cmd.code = C_PM2;
                n_state    = S_PM3;
            end
            S_PM3: begin
                o_cmd.code = C_PM3;
                n_state    = S_PM4;
            end
            S_PM4: begin
                o_cmd.code = C_PM4;
                n_state    = S_PM5;
            end
            S_PM5: begin
                o_cmd.code = C_PM5;
                n_axis     = 1'b1;
                n_state    = r_axis ? S_FIN : S_PM1;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.code  = C_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_op        <= OP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/gbi_datapath.sv
// ----------------------------------------------------------------------------
// gbi_datapath
// Body state, one shared 32x32 multiplier, a bit-serial square root and a
// restoring divider, stepped one command per cycle by the controller.
// ----------------------------------------------------------------------------
module gbi_datapath
    import gbi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_speed_x,
    input  logic signed [31:0] i_speed_y,
    input  logic        [31:0] i_other_mass,
    input  logic        [31:0] i_gain,
    input  logic        [31:0] i_step,
    output t_dp_status         o_status,
    output logic signed [31:0] o_place_x,
    output logic signed [31:0] o_place_y,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic               o_zero_distance
);

    localparam int PULL_EXP = 3 * FRAC_BITS - 55;
    localparam int PULL_SHL = (PULL_EXP >= 0) ? PULL_EXP : 0;
    localparam int PULL_SHR = (PULL_EXP < 0) ? -PULL_EXP : 0;
    localparam int ACC_SHR  = 2 * FRAC_BITS + 1;
    localparam logic [63:0] CAP32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] CAP56 = 64'h0100_0000_0000_0000;

    // Body state.
    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_acc_x, r_acc_y;
    logic               r_flag;
    // Latched item.
    logic signed [31:0] r_in_px, r_in_py, r_in_vx, r_in_vy;
    logic        [31:0] r_in_mass;
    // Working registers.
    logic signed [31:0] r_dx, r_dy;
    logic        [63:0] r_s, r_prod, r_t, r_vp, r_u;
    logic        [95:0] r_wide;
    logic        [63:0] r_sq_rem, r_sq_res, r_sq_bit;
    logic        [63:0] r_rem, r_num, r_quo, r_dvs;
    logic               r_capped;
    // Output register.
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_ax, r_o_ay;
    logic               r_o_flag;

    // Selected axis operands.
    logic signed [31:0] d_sel, a_sel, v_sel, p_sel;
    logic        [31:0] d_mag, a_mag, v_mag;
    logic signed [31:0] dx_sat, dy_sat;
    logic        [31:0] mul_a, mul_b;
    logic        [63:0] mul_p;
    logic        [63:0] sq_trial;
    logic        [64:0] div_rem2;
    logic        [127:0] pull_w;
    logic               pull_cap;
    logic        [63:0] pull_m;
    logic signed [31:0] acc_new;
    logic        [63:0] vel_sh, vel_m;
    logic signed [31:0] vel_new;
    logic        [63:0] t1_sh, t1_m, t2_m;
    logic        [95:0] t2_sh;
    logic signed [63:0] pos_sum;
    logic signed [31:0] pos_new;

    always_comb begin
        d_sel  = i_cmd.axis ? r_dy : r_dx;
        a_sel  = i_cmd.axis ? r_acc_y : r_acc_x;
        v_sel  = i_cmd.axis ? r_vel_y : r_vel_x;
        p_sel  = i_cmd.axis ? r_pos_y : r_pos_x;
        d_mag  = mag32(d_sel);
        a_mag  = mag32(a_sel);
        v_mag  = mag32(v_sel);
        dx_sat = sat32(64'(r_in_px) - 64'(r_pos_x));
        dy_sat = sat32(64'(r_in_py) - 64'(r_pos_y));
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.code)
            C_MUL_DX:  begin mul_a = mag32(r_dx); mul_b = mag32(r_dx); end
            C_MUL_DY:  begin mul_a = mag32(r_dy); mul_b = mag32(r_dy); end
            C_SQ_INIT: begin mul_a = i_gain;      mul_b = r_in_mass;   end
            C_P_LO:    begin mul_a = r_t[31:0];   mul_b = r_quo[31:0]; end
            C_P_HI:    begin mul_a = r_t[63:32];  mul_b = r_quo[31:0]; end
            C_VMUL:    begin mul_a = a_mag;       mul_b = i_step;      end
            C_PM1:     begin mul_a = v_mag;       mul_b = i_step;      end
            C_PM2:     begin mul_a = a_mag;       mul_b = i_step;      end
            C_PM3:     begin mul_a = r_u[31:0];   mul_b = i_step;      end
            C_PM4:     begin mul_a = r_u[63:32];  mul_b = i_step;      end
            default:   begin mul_a = '0;          mul_b = '0;          end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Square root, divider and the scaled update terms.
    always_comb begin
        sq_trial = r_sq_res + r_sq_bit;
        div_rem2 = {r_rem, r_num[63]};
        pull_w   = ({32'b0, r_wide} << PULL_SHL) >> PULL_SHR;
        pull_cap = (|pull_w[127:97]) || (pull_w[96:33] >= r_s);
        pull_m   = (r_capped || (r_quo > CAP32)) ? CAP32 : r_quo;
        acc_new  = d_sel[31] ? sat32(64'(a_sel) - $signed(pull_m))
                             : sat32(64'(a_sel) + $signed(pull_m));
        vel_sh   = r_wide[63:0] >> FRAC_BITS;
        vel_m    = (vel_sh > CAP32) ? CAP32 : vel_sh;
        vel_new  = a_sel[31] ? sat32(64'(v_sel) - $signed(vel_m))
                             : sat32(64'(v_sel) + $signed(vel_m));
        t1_sh    = r_vp >> FRAC_BITS;
        t1_m     = (t1_sh > CAP56) ? CAP56 : t1_sh;
        t2_sh    = r_wide >> ACC_SHR;
        t2_m     = (t2_sh > 96'(CAP56)) ? CAP56 : t2_sh[63:0];
        pos_sum  = 64'(p_sel);
        pos_sum  = v_sel[31] ? pos_sum - $signed(t1_m) : pos_sum + $signed(t1_m);
        pos_sum  = a_sel[31] ? pos_sum - $signed(t2_m) : pos_sum + $signed(t2_m);
        pos_new  = sat32(pos_sum);
    end

    // Body state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_flag  <= 1'b0;
        end else begin
            unique case (i_cmd.code)
                C_LATCH: begin
                    r_flag <= 1'b0;
                end
                C_LOAD: begin
                    r_pos_x <= r_in_px;
                    r_pos_y <= r_in_py;
                    r_vel_x <= r_in_vx;
                    r_vel_y <= r_in_vy;
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                end
                C_CLRACC: begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                end
                C_DIFF: begin
                    r_flag <= (dx_sat == '0) && (dy_sat == '0);
                end
                C_ACC: begin
                    if (i_cmd.axis) r_acc_y <= acc_new;
                    else            r_acc_x <= acc_new;
                end
                C_VADD: begin
                    if (i_cmd.axis) r_vel_y <= vel_new;
                    else            r_vel_x <= vel_new;
                end
                C_PM5: begin
                    if (i_cmd.axis) r_pos_y <= pos_new;
                    else            r_pos_x <= pos_new;
                end
                default: begin
                end
            endcase
        end
    end

    // Working and output registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.code)
            C_LATCH: begin
                r_in_px   <= i_point_x;
                r_in_py   <= i_point_y;
                r_in_vx   <= i_speed_x;
                r_in_vy   <= i_speed_y;
                r_in_mass <= i_other_mass;
            end
            C_DIFF: begin
                r_dx <= dx_sat;
                r_dy <= dy_sat;
            end
            C_MUL_DX: r_s    <= mul_p;
            C_MUL_DY: r_prod <= mul_p;
            C_SUM:    r_s    <= r_s + r_prod;
            C_SQ_INIT: begin
                r_t      <= mul_p;
                r_sq_rem <= r_s;
                r_sq_res <= '0;
                r_sq_bit <= 64'h4000_0000_0000_0000;
            end
            C_SQ_STEP: begin
                if (r_sq_rem >= sq_trial) begin
                    r_sq_rem <= r_sq_rem - sq_trial;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            C_CDIV_INIT: begin
                r_dvs <= r_sq_res;
                r_rem <= {33'b0, d_mag[31:1]};
                r_num <= {d_mag[0], 63'b0};
                r_quo <= '0;
            end
            C_DIV_STEP: begin
                if (div_rem2 >= {1'b0, r_dvs}) begin
                    r_rem <= 64'(div_rem2 - {1'b0, r_dvs});
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= div_rem2[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_num <= {r_num[62:0], 1'b0};
            end
            C_P_LO: r_wide <= {32'b0, mul_p};
            C_P_HI: r_wide <= r_wide + {mul_p, 32'b0};
            C_MDIV_INIT: begin
                r_capped <= pull_cap;
                r_dvs    <= r_s;
                r_rem    <= pull_w[96:33];
                r_num    <= {pull_w[32:0], 31'b0};
                r_quo    <= '0;
            end
            C_VMUL: r_wide <= {32'b0, mul_p};
            C_PM1:  r_vp   <= mul_p;
            C_PM2:  r_u    <= mul_p;
            C_PM3:  r_wide <= {32'b0, mul_p};
            C_PM4:  r_wide <= r_wide + {mul_p, 32'b0};
            C_PUBLISH: begin
                r_o_px   <= r_pos_x;
                r_o_py   <= r_pos_y;
                r_o_vx   <= r_vel_x;
                r_o_vy   <= r_vel_y;
                r_o_ax   <= r_acc_x;
                r_o_ay   <= r_acc_y;
                r_o_flag <= r_flag;
            end
            default: begin
            end
        endcase
    end

    assign o_status.zero_dist = r_flag;
    assign o_place_x       = r_o_px;
    assign o_place_y       = r_o_py;
    assign o_velocity_x    = r_o_vx;
    assign o_velocity_y    = r_o_vy;
    assign o_accel_x       = r_o_ax;
    assign o_accel_y       = r_o_ay;
    assign o_zero_distance = r_o_flag;

endmodule

// File: rtl/core/gravity_body_integrator.sv
// ----------------------------------------------------------------------------
// gravity_body_integrator
// One body of an n-body gravity simulation, stepped by v += a*dt and
// p += v*dt + a*dt*dt/2 in signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_axis channel carries an operation (load
// body, add attraction, update velocity, update position, clear
// acceleration) and its operands. Every item yields exactly one result item
// on the m_axis channel holding the full body state; tuser flags an
// attraction skipped because the attractor sits on the body.
// The block works on one item at a time; an attraction at zero distance
// skips the arithmetic. The attraction runs a 32-step square root and, per
// axis, a 32-step and a 33-step pass of the shared restoring divider.
// tready is high only while idle, so no new item is accepted until the
// last one has reached the output register.
// A finished result sits in an output register; the next item is accepted
// while it waits, and its own result is held back until the receiver takes
// the earlier one. Reset clears the body state to zero and loads the
// default gravity gain and time step; the configuration port writes them.
// ----------------------------------------------------------------------------
module gravity_body_integrator
    import gbi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // operation[2:0], point_x[34:3], point_y[66:35], speed_x[98:67],
    // speed_y[130:99], other_mass[162:131], zero pad[167:163]
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // place_x[31:0], place_y[63:32], velocity_x[95:64], velocity_y[127:96],
    // accel_x[159:128], accel_y[191:160]
    output logic [191:0] m_axis_tdata,
    // zero_distance[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    logic [31:0] r_gain, r_step;
    t_dp_cmd     cmd;
    t_dp_status  status;
    logic signed [31:0] px, py, vx, vy, ax, ay;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 32'd16777216;
            r_step <= 32'd655;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_GAIN: r_gain <= i_cfg_wdata;
                CFG_STEP: r_step <= i_cfg_wdata;
                default:  r_gain <= r_gain;
            endcase
        end
    end

    gbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tdata[2:0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gbi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_point_x       (s_axis_tdata[34:3]),
        .i_point_y       (s_axis_tdata[66:35]),
        .i_speed_x       (s_axis_tdata[98:67]),
        .i_speed_y       (s_axis_tdata[130:99]),
        .i_other_mass    (s_axis_tdata[162:131]),
        .i_gain          (r_gain),
        .i_step          (r_step),
        .o_status        (status),
        .o_place_x       (px),
        .o_place_y       (py),
        .o_velocity_x    (vx),
        .o_velocity_y    (vy),
        .o_accel_x       (ax),
        .o_accel_y       (ay),
        .o_zero_distance (m_axis_tuser)
    );

    assign m_axis_tdata = {ay, ax, vy, vx, py, px};

    // An accepted item keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after an accept");

    // A time step write lands in the register on the next cycle.
    a_step_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wen && (i_cfg_addr == CFG_STEP)) |=> (r_step == $past(i_cfg_wdata)))
        else $error("time step write lost");

    // A gain write lands in the register on the next cycle.
    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wen && (i_cfg_addr == CFG_GAIN)) |=> (r_gain == $past(i_cfg_wdata)))
        else $error("gravity gain write lost");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the gravity body integrator. A cycle-free
// predictor keeps its own copy of the body state and configuration, works out
// the full state that each accepted item should produce, and compares every
// result item field by field. Directed items cover the extremes and special
// cases, then random body runs go through several gain and time step settings.
// ----------------------------------------------------------------------------
module tb_top;
    import gbi_pkg::*;

    localparam int FRAC = 16;
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;
    localparam int ITEMS_PER_PHASE = 325;

    typedef struct packed {
        logic        zd;
        logic [31:0] ay;
        logic [31:0] ax;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] py;
        logic [31:0] px;
    } t_body_state;

    // Predictor of the body state plus a queue of expected result items.
    class body_scoreboard;
        longint signed px, py, vx, vy, ax, ay;
        logic [31:0] gain, dt;
        t_body_state pending[$];
        int errors;

        function new();
            px = 0; py = 0; vx = 0; vy = 0; ax = 0; ay = 0;
            gain = 32'd16777216;
            dt = 32'd655;
            errors = 0;
        endfunction

        function longint signed clamp32(longint signed v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [63:0] absval(longint signed v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function logic [63:0] root_floor(logic [63:0] s);
            logic [63:0] res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (s >= res + bitv) begin
                    s = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Signed pull along one axis: G*m*|d|/r^3, cosine in Q1.31.
        function longint signed axis_pull(longint signed d, logic [63:0] gm,
                                          logic [63:0] r, logic [63:0] s);
            logic [127:0] cosv, prod, quo;
            cosv = (128'(absval(d)) << 31) / 128'(r);
            prod = 128'(gm) * cosv;
            if (3 * FRAC - 55 >= 0) prod = prod << (3 * FRAC - 55);
            else prod = prod >> (55 - 3 * FRAC);
            quo = prod / 128'(s);
            if (quo > 128'h1_0000_0000) quo = 128'h1_0000_0000;
            return d < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function longint signed signed_term(longint signed sign_of, logic [63:0] m);
            return sign_of < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint signed vel_next(longint signed v, longint signed a);
            logic [127:0] t;
            t = (128'(absval(a)) * 128'(dt)) >> FRAC;
            if (t > 128'h1_0000_0000) t = 128'h1_0000_0000;
            return clamp32(v + signed_term(a, t[63:0]));
        endfunction

        function longint signed pos_next(longint signed p, longint signed v,
                                         longint signed a);
            logic [127:0] t1, t2;
            logic [63:0] adt;
            t1 = (128'(absval(v)) * 128'(dt)) >> FRAC;
            if (t1 > (128'd1 << 56)) t1 = 128'd1 << 56;
            adt = absval(a) * 64'(dt);
            t2 = (128'(adt) * 128'(dt)) >> (2 * FRAC + 1);
            if (t2 > (128'd1 << 56)) t2 = 128'd1 << 56;
            return clamp32(p + signed_term(v, t1[63:0]) + signed_term(a, t2[63:0]));
        endfunction

        // Apply one accepted input item and queue the state it should report.
        function void note_input(logic [167:0] d);
            logic [2:0] op;
            longint signed qx, qy, dx, dy;
            logic [63:0] s, r, gm;
            t_body_state e;
            op = d[2:0];
            qx = longint'($signed(d[34:3]));
            qy = longint'($signed(d[66:35]));
            e.zd = 1'b0;
            case (op)
                OP_LOAD: begin
                    px = qx; py = qy;
                    vx = longint'($signed(d[98:67]));
                    vy = longint'($signed(d[130:99]));
                    ax = 0; ay = 0;
                end
                OP_ATTRACT: begin
                    dx = clamp32(qx - px);
                    dy = clamp32(qy - py);
                    if (dx == 0 && dy == 0) begin
                        e.zd = 1'b1;
                    end else begin
                        s = 64'(dx * dx) + 64'(dy * dy);
                        r = root_floor(s);
                        gm = 64'(gain) * 64'(d[162:131]);
                        ax = clamp32(ax + axis_pull(dx, gm, r, s));
                        ay = clamp32(ay + axis_pull(dy, gm, r, s));
                    end
                end
                OP_VEL: begin
                    vx = vel_next(vx, ax);
                    vy = vel_next(vy, ay);
                end
                OP_POS: begin
                    px = pos_next(px, vx, ax);
                    py = pos_next(py, vy, ay);
                end
                OP_CLRACC: begin
                    ax = 0; ay = 0;
                end
                default: ;
            endcase
            e.px = px[31:0]; e.py = py[31:0];
            e.vx = vx[31:0]; e.vy = vy[31:0];
            e.ax = ax[31:0]; e.ay = ay[31:0];
            pending.push_back(e);
        endfunction

        function void report(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 60)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                         want, got);
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_result(logic [191:0] d, logic zd);
            t_body_state e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, d);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.px) report("place_x", e.px, d[31:0]);
            if (d[63:32] !== e.py) report("place_y", e.py, d[63:32]);
            if (d[95:64] !== e.vx) report("velocity_x", e.vx, d[95:64]);
            if (d[127:96] !== e.vy) report("velocity_y", e.vy, d[127:96]);
            if (d[159:128] !== e.ax) report("accel_x", e.ax, d[159:128]);
            if (d[191:160] !== e.ay) report("accel_y", e.ay, d[191:160]);
            if (zd !== e.zd) report("zero_distance", 32'(e.zd), 32'(zd));
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_wen;
    logic         i_cfg_addr;
    logic [31:0]  i_cfg_wdata;

    body_scoreboard sb;
    int burst_left;
    int stall_mode;
    int stall_count;

    gravity_body_integrator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Handshake monitor: both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Receiver back-pressure: switches between always ready, random and long stalls.
    always @(negedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_count = $urandom_range(50, 600);
        end else begin
            stall_count--;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Send one item, opening a new burst after a random gap when needed.
    task automatic send_item(logic [2:0] op, logic [31:0] qx, logic [31:0] qy,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] mass);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata <= {5'd0, mass, sy, sx, qy, qx, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == CFG_GAIN) sb.gain = val;
        else sb.dt = val;
    endtask

    // Coordinate or speed value: mostly modest, sometimes full range or extreme.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom();
            4: return 32'($signed($urandom_range(0, 255)) - 128);
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // Random run: load, 1-6 mostly pulls, then steps; 1 in 10 is one random item.
    task automatic random_run(inout int sent);
        int n;
        logic [2:0] op;
        if ($urandom_range(0, 9) == 0) begin
            op = 3'($urandom_range(0, 7));
            send_item(op, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            sent++;
            return;
        end
        send_item(OP_LOAD, pick_word(), pick_word(), pick_word(), pick_word(),
                  $urandom());
        sent++;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0: send_item(OP_ATTRACT, sb.px[31:0], sb.py[31:0], $urandom(),
                             $urandom(), pick_mass());
                1: send_item(OP_VEL, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom());
                2: send_item(OP_POS, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom());
                3: send_item(OP_CLRACC, $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom());
                4: send_item(3'($urandom_range(OP_BAD_LO, OP_BAD_HI)), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom());
                default: send_item(OP_ATTRACT, pick_word(), pick_word(), $urandom(),
                                   $urandom(), pick_mass());
            endcase
            sent++;
        end
        repeat ($urandom_range(1, 4)) begin
            send_item(OP_VEL, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
            send_item(OP_POS, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
            sent += 2;
        end
    endtask

    task automatic random_phase();
        int sent;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) random_run(sent);
        drain();
    endtask

    // Main sequence.
    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_addr = CFG_GAIN;
        i_cfg_wdata = '0;
        burst_left = 0;
        stall_mode = 0;
        stall_count = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, zero distance, far attractor, unknown operations.
        send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_ATTRACT, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 32'hFFFF_FFFF);
        send_item(OP_ATTRACT, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, 32'd7);
        send_item(OP_VEL, '1, '1, '1, '1, '1);
        send_item(OP_POS, '0, '0, '0, '0, '0);
        send_item(OP_CLRACC, '1, '1, '1, '1, '1);
        send_item(OP_BAD_LO, '1, '1, '1, '1, '1);
        send_item(3'd6, '0, '0, '0, '0, '0);
        send_item(OP_BAD_HI, '1, '0, '1, '0, '1);
        send_item(OP_LOAD, '0, '0, '0, '0, '0);
        send_item(OP_ATTRACT, '0, '0, '0, '0, 32'd100);
        send_item(OP_ATTRACT, 32'h0001_0000, '0, '0, '0, '0);
        send_item(OP_ATTRACT, '0, 32'hFFFF_0000, '0, '0, 32'hFFFF_FFFF);
        send_item(OP_ATTRACT, 32'd1, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF);
        send_item(OP_VEL, '0, '0, '0, '0, '0);
        send_item(OP_POS, '0, '0, '0, '0, '0);
        send_item(OP_POS, '0, '0, '0, '0, '0);
        send_item(OP_LOAD, 32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, '0);
        send_item(OP_POS, '0, '0, '0, '0, '0);
        send_item(OP_ATTRACT, 32'h0010_0000, 32'hFFF0_0000, '0, '0, 32'd5);
        drain();

        random_phase();
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_STEP, 32'hFFFF_FFFF);
        random_phase();
        write_reg(CFG_GAIN, 32'd0);
        write_reg(CFG_STEP, 32'd0);
        random_phase();
        write_reg(CFG_GAIN, $urandom());
        write_reg(CFG_STEP, $urandom_range(1, 32'h0004_0000));
        random_phase();
        write_reg(CFG_GAIN, $urandom_range(1, 32'h0100_0000));
        write_reg(CFG_STEP, $urandom());
        random_phase();
        write_reg(CFG_GAIN, 32'd16777216);
        write_reg(CFG_STEP, 32'd655);
        random_phase();

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
